// File: sv/uue_pkg.sv
// uue_pkg: shared types, encoding codes and the code point encoder function.
// No dependencies; imported by every module of the unicode_utf_encoder block.
package uue_pkg;

    localparam int unsigned CP_W   = 32;
    localparam int unsigned ENC_W  = 3;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned NBYTES = 4;
    localparam int unsigned IDX_W  = 2;

    localparam logic [ENC_W-1:0] ENC_UTF8     = 3'd0;
    localparam logic [ENC_W-1:0] ENC_UTF16_BE = 3'd1;
    localparam logic [ENC_W-1:0] ENC_UTF16_LE = 3'd2;
    localparam logic [ENC_W-1:0] ENC_UTF32_BE = 3'd3;
    localparam logic [ENC_W-1:0] ENC_UTF32_LE = 3'd4;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 32'h0000_FFFD;
    localparam logic [CP_W-1:0] CP_SURR_LO     = 32'h0000_D800;
    localparam logic [CP_W-1:0] CP_SURR_HI     = 32'h0000_DFFF;
    localparam logic [CP_W-1:0] CP_LIMIT       = 32'h0011_0000;
    localparam logic [CP_W-1:0] CP_2BYTE       = 32'h0000_0080;
    localparam logic [CP_W-1:0] CP_3BYTE       = 32'h0000_0800;
    localparam logic [CP_W-1:0] CP_SUPP        = 32'h0001_0000;

    // One encoded code point: bytes in transmission order, index of the last one.
    typedef struct packed {
        logic [NBYTES-1:0][BYTE_W-1:0] bytes;
        logic [IDX_W-1:0]              last_idx;
    } enc_word_t;

    function automatic enc_word_t encode_cp(input logic [CP_W-1:0]  cp_in,
                                            input logic [ENC_W-1:0] enc);
        logic [CP_W-1:0]  cp;
        logic [19:0]      v;
        logic [15:0]      hi_unit;
        logic [15:0]      lo_unit;
        logic             big;
        enc_word_t        w;
        if ((cp_in >= CP_SURR_LO && cp_in <= CP_SURR_HI) || cp_in >= CP_LIMIT) begin
            cp = CP_REPLACEMENT;
        end else begin
            cp = cp_in;
        end
        v       = cp[19:0] - CP_SUPP[19:0];
        hi_unit = 16'hD800 | {6'd0, v[19:10]};
        lo_unit = 16'hDC00 | {6'd0, v[9:0]};
        big     = (enc == ENC_UTF16_BE) || (enc == ENC_UTF32_BE);
        w       = '0;
        unique case (enc)
            ENC_UTF16_BE, ENC_UTF16_LE: begin
                if (cp < CP_SUPP) begin
                    w.bytes[0] = big ? cp[15:8] : cp[7:0];
                    w.bytes[1] = big ? cp[7:0]  : cp[15:8];
                    w.last_idx = 2'd1;
                end else begin
                    w.bytes[0] = big ? hi_unit[15:8] : hi_unit[7:0];
                    w.bytes[1] = big ? hi_unit[7:0]  : hi_unit[15:8];
                    w.bytes[2] = big ? lo_unit[15:8] : lo_unit[7:0];
                    w.bytes[3] = big ? lo_unit[7:0]  : lo_unit[15:8];
                    w.last_idx = 2'd3;
                end
            end
            ENC_UTF32_BE: begin
                w.bytes    = {cp[7:0], cp[15:8], cp[23:16], cp[31:24]};
                w.last_idx = 2'd3;
            end
            ENC_UTF32_LE: begin
                w.bytes    = {cp[31:24], cp[23:16], cp[15:8], cp[7:0]};
                w.last_idx = 2'd3;
            end
            default: begin
                // UTF-8, also for the unused selector codes
                if (cp < CP_2BYTE) begin
                    w.bytes[0] = cp[7:0];
                    w.last_idx = 2'd0;
                end else if (cp < CP_3BYTE) begin
                    w.bytes[0] = 8'hC0 | {3'd0, cp[10:6]};
                    w.bytes[1] = 8'h80 | {2'd0, cp[5:0]};
                    w.last_idx = 2'd1;
                end else if (cp < CP_SUPP) begin
                    w.bytes[0] = 8'hE0 | {4'd0, cp[15:12]};
                    w.bytes[1] = 8'h80 | {2'd0, cp[11:6]};
                    w.bytes[2] = 8'h80 | {2'd0, cp[5:0]};
                    w.last_idx = 2'd2;
                end else begin
                    w.bytes[0] = 8'hF0 | {5'd0, cp[20:18]};
                    w.bytes[1] = 8'h80 | {2'd0, cp[17:12]};
                    w.bytes[2] = 8'h80 | {2'd0, cp[11:6]};
                    w.bytes[3] = 8'h80 | {2'd0, cp[5:0]};
                    w.last_idx = 2'd3;
                end
            end
        endcase
        return w;
    endfunction

endpackage

// File: sv/uue_front.sv
// uue_front: encoding select register, input handshake and code point encoding.
// Depends on uue_pkg.
module uue_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [uue_pkg::ENC_W-1:0]   cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [uue_pkg::CP_W-1:0]    s_code_point,
    input  logic                        q_full,
    output logic                        q_push,
    output uue_pkg::enc_word_t          q_wdata
);
    import uue_pkg::*;

    logic [ENC_W-1:0] enc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enc_reg <= ENC_UTF8;
        end else if (cfg_we) begin
            enc_reg <= cfg_wdata;
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign q_wdata = encode_cp(s_code_point, enc_reg);

endmodule

// File: sv/uue_queue.sv
// uue_queue: two-entry queue of encoded code points between front and back.
// Depends on uue_pkg.
module uue_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  uue_pkg::enc_word_t  wdata,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output uue_pkg::enc_word_t  rdata
);
    import uue_pkg::*;

    enc_word_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: sv/uue_back.sv
// uue_back: byte serializer with registered output stage.
// Depends on uue_pkg.
module uue_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_empty,
    input  uue_pkg::enc_word_t          q_rdata,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [uue_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                        m_last_byte
);
    import uue_pkg::*;

    logic [IDX_W-1:0]  idx_reg,   idx_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg,  byte_next;
    logic              last_reg,  last_next;
    logic              load;
    logic              is_last;

    assign load    = (!valid_reg || m_ready) && !q_empty;
    assign is_last = (idx_reg == q_rdata.last_idx);
    assign q_pop   = load && is_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            byte_next  = q_rdata.bytes[idx_reg];
            last_next  = is_last;
            idx_next   = is_last ? '0 : idx_reg + 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_valid     = valid_reg;
    assign m_out_byte  = byte_reg;
    assign m_last_byte = last_reg;

endmodule

// File: sv/unicode_utf_encoder.sv
// unicode_utf_encoder: code point to UTF-8/16/32 byte stream, one byte per transfer.
// Path: encoded code points enter the queue; bytes leave via the output register.
// Throughput: one byte per cycle while m_ready is high, set by the single output
// register; a code point is 1 to 4 bytes (UTF-8 1..4, UTF-16 2 or 4, UTF-32 4).
// Reset: synchronous active-low aresetn empties the queue and output, selects UTF-8.
// Depends on uue_pkg, uue_front, uue_queue, uue_back.
module unicode_utf_encoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    // encoding select register: 0 UTF-8, 1/2 UTF-16 BE/LE, 3/4 UTF-32 BE/LE
    input  logic                        cfg_we,
    input  logic [uue_pkg::ENC_W-1:0]   cfg_wdata,
    // code point input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [uue_pkg::CP_W-1:0]    s_code_point,
    // byte output
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [uue_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                        m_last_byte
);
    import uue_pkg::*;

    // front to queue
    logic      q_push;
    logic      q_full;
    enc_word_t q_wdata;
    // queue to back
    logic      q_pop;
    logic      q_empty;
    enc_word_t q_rdata;

    // Front: validate the code point, substitute U+FFFD where needed, and
    // build the full byte sequence in one step. Stall only when the queue is full.
    uue_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_code_point (s_code_point),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_wdata      (q_wdata)
    );

    // Queue: hold up to two encoded code points so the front keeps taking
    // transfers while the back is still draining a long encoding.
    uue_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rdata   (q_rdata)
    );

    // Back: advance through the bytes of the queue head, one per output
    // transfer, and drop the head when its last byte is loaded.
    uue_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

endmodule

// File: sv/uue_checker.sv
// uue_checker: port-level assertions for unicode_utf_encoder, bound to the top level.
// Depends on uue_pkg.
module uue_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [uue_pkg::BYTE_W-1:0]  m_out_byte,
    input logic                        m_last_byte
);
    import uue_pkg::*;

    logic [IDX_W-1:0] run_reg;      // non-last bytes sent in the current code point
    logic [2:0]       pending_reg;  // code points taken but not finished

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= '0;
            pending_reg <= '0;
        end else begin
            if (m_valid && m_ready) begin
                run_reg <= m_last_byte ? '0 : run_reg + 1'b1;
            end
            pending_reg <= pending_reg + {2'd0, s_valid && s_ready}
                           - {2'd0, m_valid && m_ready && m_last_byte};
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last_byte))
        else $error("output changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

    a_max_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && run_reg == 2'd3 |-> m_last_byte)
        else $error("encoding longer than four bytes");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 3'd0)
        else $error("output byte without a pending code point");

endmodule

bind unicode_utf_encoder uue_checker u_uue_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_byte  (m_out_byte),
    .m_last_byte (m_last_byte)
);
